/* hdl/jgrr_pkg.sv */
package jgrr_pkg;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int ROW_LIMIT      = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int JOINT_W   = 5;
  localparam int VALUE_W   = 32;
  localparam int GAIN_W    = 31;
  localparam int ELAPSED_W = 20;
  localparam int COUNT_W   = 6;
  localparam int TIME_W    = 27;
  localparam int RATIO_W   = 17;
  localparam int PROD_W    = GAIN_W + RATIO_W;
  localparam int FRAC_W    = 16;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 104;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_W);

  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIME = 1'b1;

  localparam logic [COUNT_W-1:0] JOINT_COUNT_RST  = 6'd32;
  localparam logic [TIME_W-1:0]  RELEASE_TIME_RST = 27'd1000000;

  localparam logic [1:0] SRC_POLICY = 2'd0;
  localparam logic [1:0] SRC_SAFETY = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ENTER = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_ROWS
  } back_state_t;

  // One decoded item as it waits between front and back.
  typedef struct packed {
    kind_t                  kind;
    logic [JOINT_W-1:0]     joint;
    logic [VALUE_W-1:0]     pos;
    logic [VALUE_W-1:0]     kp;
    logic [VALUE_W-1:0]     kd;
    logic                   ok;
    logic                   arm;
    logic [ELAPSED_W-1:0]   elapsed;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic               last;
    logic               en;
    logic               fin;
    logic               tgt;
    logic [RATIO_W-1:0] ratio;
  } row_meta_t;

endpackage

/* hdl/jgrr_ram.sv */
module jgrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* hdl/jgrr_front.sv */
module jgrr_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [jgrr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [jgrr_pkg::KIND_W-1:0]        in_tuser,
  input  jgrr_pkg::queue_status_t            q_status,
  output logic                               push,
  output jgrr_pkg::cmd_t                     push_cmd
);

  logic       drive_enabled;
  logic       fault_active;
  logic [1:0] fault_source;
  logic       fault_limit;
  logic       finite;
  logic       known_kind;

  assign finite        = in_tdata[37];
  assign drive_enabled = in_tdata[102];
  assign fault_active  = in_tdata[103];
  assign fault_source  = in_tdata[105:104];
  assign fault_limit   = in_tdata[106];

  assign known_kind = (in_tuser == jgrr_pkg::KIND_LOAD) ||
                      (in_tuser == jgrr_pkg::KIND_ENTER) ||
                      (in_tuser == jgrr_pkg::KIND_TICK);

  assign in_tready = !q_status.full;
  // Items of an unknown kind are taken and dropped here.
  assign push      = in_tvalid && in_tready && known_kind;

  always_comb begin
    push_cmd.kind    = jgrr_pkg::kind_t'(in_tuser);
    push_cmd.joint   = in_tdata[4:0];
    push_cmd.pos     = in_tdata[36:5];
    push_cmd.kp      = in_tdata[69:38];
    push_cmd.kd      = in_tdata[101:70];
    push_cmd.ok      = finite && !in_tdata[69] && !in_tdata[101];
    push_cmd.arm     = drive_enabled && fault_active &&
                       ((fault_source == jgrr_pkg::SRC_POLICY) ||
                        ((fault_source == jgrr_pkg::SRC_SAFETY) && fault_limit));
    push_cmd.elapsed = in_tdata[126:107];
  end

endmodule

/* hdl/jgrr_queue.sv */
module jgrr_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  jgrr_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output jgrr_pkg::cmd_t          head_cmd,
  output jgrr_pkg::queue_status_t status
);

  localparam int Depth = jgrr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  jgrr_pkg::cmd_t    slot_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (int'(p) == Depth - 1) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = slot_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.full  = (int'(count_r) == Depth);

endmodule

/* hdl/jgrr_back.sv */
module jgrr_back #(
  parameter int MAX_JOINTS = jgrr_pkg::MAX_JOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jgrr_pkg::cmd_t                    cmd,
  input  jgrr_pkg::queue_status_t           q_status,
  output logic                              pop,
  input  logic [jgrr_pkg::COUNT_W-1:0]      joint_count,
  input  logic [jgrr_pkg::TIME_W-1:0]       release_time,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [jgrr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  localparam int AddrW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int RowMax = (MAX_JOINTS < jgrr_pkg::ROW_LIMIT) ? MAX_JOINTS : jgrr_pkg::ROW_LIMIT;
  localparam int VW     = jgrr_pkg::VALUE_W;
  localparam int GW     = jgrr_pkg::GAIN_W;
  localparam int RW     = jgrr_pkg::RATIO_W;
  localparam int PW     = jgrr_pkg::PROD_W;
  localparam int TW     = jgrr_pkg::TIME_W;
  localparam int CW     = jgrr_pkg::COUNT_W;
  localparam int JW     = jgrr_pkg::JOINT_W;
  localparam int FW     = jgrr_pkg::FRAC_W;

  jgrr_pkg::back_state_t state_r, state_nxt;

  logic [MAX_JOINTS-1:0] loaded_r, loaded_nxt;
  logic [MAX_JOINTS-1:0] valid_r, valid_nxt;
  logic [VW-1:0]         elapsed_r, elapsed_nxt;
  logic                  ramp_r, ramp_nxt;

  logic                  row_en_r, row_en_nxt;
  logic                  row_fin_r, row_fin_nxt;
  logic                  row_tgt_r, row_tgt_nxt;
  logic [RW-1:0]         row_ratio_r, row_ratio_nxt;
  logic [JW-1:0]         row_k_r, row_k_nxt;

  logic [TW:0]           div_rem_r, div_rem_nxt;
  logic [RW-1:0]         div_q_r, div_q_nxt;
  logic [4:0]            div_cnt_r, div_cnt_nxt;

  logic [CW-1:0]         n_rows;
  logic [MAX_JOINTS-1:0] need;
  logic [MAX_JOINTS-1:0] jbit;
  logic                  all_ok;
  logic                  enter_allow;
  logic                  in_range;
  logic [VW:0]           sum;
  logic [VW-1:0]         t_new;
  logic                  tick_ramping;
  logic                  div_ge;
  logic [TW:0]           div_diff;
  logic                  adv;
  logic                  issue;
  logic                  is_last;
  logic                  ram_we;

  logic [3*VW-1:0]       ram_rdata;
  logic [VW-1:0]         rd_pos;
  logic [VW-1:0]         rd_kp;
  logic [VW-1:0]         rd_kd;

  logic                  s1_valid_r;
  jgrr_pkg::row_meta_t   s1_meta_r;
  jgrr_pkg::row_meta_t   issue_meta;
  logic                  s2_valid_r;
  jgrr_pkg::row_meta_t   s2_meta_r;
  logic [VW-1:0]         s2_target_r;
  logic [PW-1:0]         kp_prod_r;
  logic [PW-1:0]         kd_prod_r;

  logic                  out_valid_r;
  logic [JW-1:0]         out_joint_r;
  logic                  out_en_r;
  logic [VW-1:0]         out_target_r;
  logic [GW-1:0]         out_kp_r;
  logic [GW-1:0]         out_kd_r;
  logic                  out_fin_r;
  logic                  out_last_r;

  // Row count saturates at the joint storage size and at the row limit.
  assign n_rows = (int'(joint_count) > RowMax) ? CW'(RowMax) : joint_count;

  always_comb begin
    for (int i = 0; i < MAX_JOINTS; i++) begin
      need[i] = (i < int'(n_rows));
      jbit[i] = (int'(cmd.joint) == i);
    end
  end

  assign all_ok      = (n_rows != '0) && (((loaded_r & valid_r) & need) == need);
  assign enter_allow = cmd.arm && all_ok;
  assign in_range    = int'(cmd.joint) < MAX_JOINTS;

  assign sum          = {1'b0, elapsed_r} + (VW+1)'(cmd.elapsed);
  assign t_new        = sum[VW] ? '1 : sum[VW-1:0];
  assign tick_ramping = ramp_r && (t_new < VW'(release_time));

  assign div_ge   = div_rem_r >= {1'b0, release_time};
  assign div_diff = div_ge ? div_rem_r - {1'b0, release_time} : div_rem_r;

  assign adv     = !out_valid_r || out_tready;
  assign is_last = ({1'b0, row_k_r} + CW'(1)) == n_rows;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jgrr_pkg::B_IDLE: begin
        if (q_status.valid) begin
          case (cmd.kind)
            jgrr_pkg::KIND_ENTER: begin
              if (n_rows != '0) state_nxt = jgrr_pkg::B_ROWS;
            end
            jgrr_pkg::KIND_TICK: begin
              if (tick_ramping) state_nxt = jgrr_pkg::B_DIV;
              else if (n_rows != '0) state_nxt = jgrr_pkg::B_ROWS;
            end
            default: state_nxt = jgrr_pkg::B_IDLE;
          endcase
        end
      end
      jgrr_pkg::B_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = (n_rows != '0) ? jgrr_pkg::B_ROWS : jgrr_pkg::B_IDLE;
        end
      end
      jgrr_pkg::B_ROWS: begin
        if (adv && is_last) state_nxt = jgrr_pkg::B_IDLE;
      end
      default: state_nxt = jgrr_pkg::B_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    pop    = 1'b0;
    issue  = 1'b0;
    ram_we = 1'b0;
    case (state_r)
      jgrr_pkg::B_IDLE: begin
        pop    = q_status.valid;
        ram_we = q_status.valid && (cmd.kind == jgrr_pkg::KIND_LOAD) && in_range;
      end
      jgrr_pkg::B_ROWS: begin
        issue = adv;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Item state, row parameters and the ratio divider.
  always_comb begin
    loaded_nxt    = loaded_r;
    valid_nxt     = valid_r;
    elapsed_nxt   = elapsed_r;
    ramp_nxt      = ramp_r;
    row_en_nxt    = row_en_r;
    row_fin_nxt   = row_fin_r;
    row_tgt_nxt   = row_tgt_r;
    row_ratio_nxt = row_ratio_r;
    row_k_nxt     = row_k_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    div_cnt_nxt   = div_cnt_r;
    case (state_r)
      jgrr_pkg::B_IDLE: begin
        if (q_status.valid) begin
          case (cmd.kind)
            jgrr_pkg::KIND_LOAD: begin
              if (in_range) begin
                loaded_nxt = loaded_r | jbit;
                valid_nxt  = cmd.ok ? (valid_r | jbit) : (valid_r & ~jbit);
              end
            end
            jgrr_pkg::KIND_ENTER: begin
              elapsed_nxt   = '0;
              ramp_nxt      = enter_allow;
              row_en_nxt    = enter_allow;
              row_fin_nxt   = 1'b0;
              row_tgt_nxt   = enter_allow;
              row_ratio_nxt = enter_allow ? jgrr_pkg::RATIO_ONE : '0;
              row_k_nxt     = '0;
            end
            jgrr_pkg::KIND_TICK: begin
              elapsed_nxt = t_new;
              row_tgt_nxt = ramp_r;
              row_k_nxt   = '0;
              if (tick_ramping) begin
                row_en_nxt  = 1'b1;
                row_fin_nxt = 1'b0;
                div_rem_nxt = {1'b0, release_time} - {1'b0, t_new[TW-1:0]};
                div_q_nxt   = '0;
                div_cnt_nxt = 5'(RW - 1);
              end else begin
                row_en_nxt    = 1'b0;
                row_fin_nxt   = 1'b1;
                row_ratio_nxt = '0;
              end
            end
            default: begin
              row_k_nxt = row_k_r;
            end
          endcase
        end
      end
      jgrr_pkg::B_DIV: begin
        // One quotient bit of (T - t) * 2^16 / T per cycle, most significant first.
        div_rem_nxt = {div_diff[TW-1:0], 1'b0};
        div_q_nxt   = {div_q_r[RW-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) row_ratio_nxt = {div_q_r[RW-2:0], div_ge};
      end
      jgrr_pkg::B_ROWS: begin
        if (issue) row_k_nxt = row_k_r + JW'(1);
      end
      default: begin
        row_k_nxt = row_k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= jgrr_pkg::B_IDLE;
      loaded_r  <= '0;
      valid_r   <= '0;
      elapsed_r <= '0;
      ramp_r    <= 1'b0;
      row_k_r   <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      valid_r   <= valid_nxt;
      elapsed_r <= elapsed_nxt;
      ramp_r    <= ramp_nxt;
      row_k_r   <= row_k_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_en_r    <= row_en_nxt;
    row_fin_r   <= row_fin_nxt;
    row_tgt_r   <= row_tgt_nxt;
    row_ratio_r <= row_ratio_nxt;
    div_rem_r   <= div_rem_nxt;
    div_q_r     <= div_q_nxt;
  end

  jgrr_ram #(
    .WIDTH (3 * VW),
    .DEPTH (MAX_JOINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AddrW'(cmd.joint)),
    .wdata ({cmd.pos, cmd.kp, cmd.kd}),
    .re    (adv),
    .raddr (AddrW'(row_k_r)),
    .rdata (ram_rdata)
  );

  assign rd_pos = ram_rdata[3*VW-1:2*VW];
  assign rd_kp  = ram_rdata[2*VW-1:VW];
  assign rd_kd  = ram_rdata[VW-1:0];

  always_comb begin
    issue_meta.joint = row_k_r;
    issue_meta.last  = is_last;
    issue_meta.en    = row_en_r;
    issue_meta.fin   = row_fin_r;
    issue_meta.tgt   = row_tgt_r;
    issue_meta.ratio = row_ratio_r;
  end

  // Row pipeline: store read, gain scaling, output register. Every stage
  // moves together and holds while a finished beat waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Rows with the drive off carry zero gains, whatever the store holds for that joint.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r    <= issue_meta;
      s2_meta_r    <= s1_meta_r;
      s2_target_r  <= s1_meta_r.tgt ? rd_pos : '0;
      kp_prod_r    <= s1_meta_r.en ?
                      {{RW{1'b0}}, rd_kp[GW-1:0]} * {{GW{1'b0}}, s1_meta_r.ratio} : '0;
      kd_prod_r    <= s1_meta_r.en ?
                      {{RW{1'b0}}, rd_kd[GW-1:0]} * {{GW{1'b0}}, s1_meta_r.ratio} : '0;
      out_joint_r  <= s2_meta_r.joint;
      out_en_r     <= s2_meta_r.en;
      out_target_r <= s2_target_r;
      out_kp_r     <= kp_prod_r[GW+FW-1:FW];
      out_kd_r     <= kd_prod_r[GW+FW-1:FW];
      out_fin_r    <= s2_meta_r.fin;
      out_last_r   <= s2_meta_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_fin_r, out_kd_r, out_kp_r, out_target_r,
                       out_en_r, out_joint_r};

endmodule

/* hdl/joint_gain_release_ramp.sv */
// Gain release sequencer for up to 32 joints. Load items store a joint's
// position and gains. An enter item decides on the ramp and sends one beat
// per joint in use. A tick item adds its elapsed time to a saturating timer;
// while ramping it first runs a bit-serial divider that forms the Q1.16
// ratio (T - t) / T, then sends one beat per joint with both gains scaled by
// that ratio; otherwise it sends finished beats with zero gains. Beats leave
// at one per cycle while the output is ready, through a three-stage row
// pipeline (store read, multiply, output register). A two-entry queue sits
// between input decode and execution, so new items are taken while earlier
// rows are still going out. Configuration may only be written while the
// block is idle.
module joint_gain_release_ramp #(
  parameter int MAX_JOINTS = jgrr_pkg::MAX_JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // joint_index, joint_position, values_finite, kp_gain, kd_gain,
  // drive_enabled, fault_active, fault_source, fault_limit_code, elapsed_us
  input  logic [jgrr_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  logic [jgrr_pkg::KIND_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_joint, drive_enable, target_position, kp_out, kd_out, finished
  output logic [jgrr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [jgrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jgrr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [jgrr_pkg::COUNT_W-1:0] joint_count_r;
  logic [jgrr_pkg::TIME_W-1:0]  release_time_r;

  logic                    push;
  jgrr_pkg::cmd_t          push_cmd;
  logic                    pop;
  jgrr_pkg::cmd_t          head_cmd;
  jgrr_pkg::queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r  <= jgrr_pkg::JOINT_COUNT_RST;
      release_time_r <= jgrr_pkg::RELEASE_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jgrr_pkg::CFG_JOINT_COUNT:  joint_count_r  <= cfg_wdata[jgrr_pkg::COUNT_W-1:0];
        jgrr_pkg::CFG_RELEASE_TIME: release_time_r <= cfg_wdata;
        default:                    joint_count_r  <= joint_count_r;
      endcase
    end
  end

  jgrr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  jgrr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  jgrr_back #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (head_cmd),
    .q_status     (q_status),
    .pop          (pop),
    .joint_count  (joint_count_r),
    .release_time (release_time_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

/* tb/tb_joint_gain_release_ramp.sv */
module tb_joint_gain_release_ramp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [jgrr_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] SRC_OTHER  = 2'd2;
  localparam logic [1:0] SRC_UNUSED = 2'd3;

  localparam int unsigned ELAPSED_MAX_US = 1000000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned RANDOM_ITEMS   = 150;
  localparam int unsigned SOAK_TICKS     = 104;

  // Input beat layout, highest field first so that joint_index lands in bit 0.
  typedef struct packed {
    logic                           pad;
    logic [jgrr_pkg::ELAPSED_W-1:0] elapsed_us;
    logic                           fault_limit_code;
    logic [1:0]                     fault_source;
    logic                           fault_active;
    logic                           drive_enabled;
    logic [31:0]                    kd_gain;
    logic [31:0]                    kp_gain;
    logic                           values_finite;
    logic [31:0]                    joint_position;
    logic [jgrr_pkg::JOINT_W-1:0]   joint_index;
  } drive_cmd_t;

  typedef struct packed {
    logic [2:0]                   pad;
    logic                         finished;
    logic [jgrr_pkg::GAIN_W-1:0]  kd_out;
    logic [jgrr_pkg::GAIN_W-1:0]  kp_out;
    logic [31:0]                  target_position;
    logic                         drive_enable;
    logic [jgrr_pkg::JOINT_W-1:0] joint;
  } joint_row_t;

  typedef struct {
    joint_row_t row;
    logic       last;
  } row_expect_t;

  class release_scoreboard;
    logic [31:0]                  hold_pos [jgrr_pkg::ROW_LIMIT];
    logic [31:0]                  kp_init [jgrr_pkg::ROW_LIMIT];
    logic [31:0]                  kd_init [jgrr_pkg::ROW_LIMIT];
    logic [31:0]                  loaded;
    logic [31:0]                  valid;
    logic [31:0]                  elapsed_total;
    bit                           ramp_on;
    logic [jgrr_pkg::COUNT_W-1:0] joint_count;
    logic [jgrr_pkg::TIME_W-1:0]  release_us;
    row_expect_t                  rows_due [$];
    int unsigned                  errors;
    int unsigned                  rows_seen;

    function new();
      loaded        = '0;
      valid         = '0;
      elapsed_total = '0;
      ramp_on       = 1'b0;
      joint_count   = jgrr_pkg::JOINT_COUNT_RST;
      release_us    = jgrr_pkg::RELEASE_TIME_RST;
      errors        = 0;
      rows_seen     = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void write_reg(logic [jgrr_pkg::CFG_IDX_W-1:0] idx,
                            logic [jgrr_pkg::CFG_DATA_W-1:0] value);
      if (idx == jgrr_pkg::CFG_JOINT_COUNT) joint_count = value[jgrr_pkg::COUNT_W-1:0];
      else release_us = value;
    endfunction

    function logic [jgrr_pkg::GAIN_W-1:0] scaled(logic [31:0] gain, logic [63:0] ratio);
      logic [63:0] prod;
      prod = 64'(gain[jgrr_pkg::GAIN_W-1:0]) * ratio;
      return prod[jgrr_pkg::GAIN_W+jgrr_pkg::FRAC_W-1:jgrr_pkg::FRAC_W];
    endfunction

    function void add_row(int unsigned k, int unsigned n, bit en, logic [31:0] tgt,
                          logic [jgrr_pkg::GAIN_W-1:0] kp,
                          logic [jgrr_pkg::GAIN_W-1:0] kd, bit fin);
      row_expect_t e;
      e.row = '0;
      e.row.joint           = k[jgrr_pkg::JOINT_W-1:0];
      e.row.drive_enable    = en;
      e.row.target_position = tgt;
      e.row.kp_out          = kp;
      e.row.kd_out          = kd;
      e.row.finished        = fin;
      e.last                = (k + 1 == n);
      rows_due.push_back(e);
    endfunction

    function void note_item(logic [jgrr_pkg::KIND_W-1:0] kind, drive_cmd_t c);
      int unsigned n;
      bit          fault_ok;
      bit          all_ok;
      bit          ramping;
      logic [63:0] sum;
      logic [63:0] ratio;
      n = (joint_count > jgrr_pkg::ROW_LIMIT) ? jgrr_pkg::ROW_LIMIT : joint_count;
      case (kind)
        jgrr_pkg::KIND_LOAD: begin
          hold_pos[c.joint_index] = c.joint_position;
          kp_init[c.joint_index]  = c.kp_gain;
          kd_init[c.joint_index]  = c.kd_gain;
          loaded[c.joint_index]   = 1'b1;
          valid[c.joint_index]    = c.values_finite && !c.kp_gain[31] && !c.kd_gain[31];
        end
        jgrr_pkg::KIND_ENTER: begin
          fault_ok = c.fault_active && (c.fault_source == jgrr_pkg::SRC_POLICY ||
                     (c.fault_source == jgrr_pkg::SRC_SAFETY && c.fault_limit_code));
          all_ok = (n > 0);
          for (int k = 0; k < n; k++) begin
            if (!loaded[k] || !valid[k]) all_ok = 1'b0;
          end
          elapsed_total = '0;
          ramp_on = c.drive_enabled && fault_ok && all_ok;
          for (int k = 0; k < n; k++) begin
            if (ramp_on) begin
              add_row(k, n, 1'b1, hold_pos[k], kp_init[k][jgrr_pkg::GAIN_W-1:0],
                      kd_init[k][jgrr_pkg::GAIN_W-1:0], 1'b0);
            end else begin
              add_row(k, n, 1'b0, '0, '0, '0, 1'b0);
            end
          end
        end
        jgrr_pkg::KIND_TICK: begin
          sum = 64'(elapsed_total) + 64'(c.elapsed_us);
          elapsed_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
          ramping = ramp_on && (elapsed_total < 32'(release_us));
          ratio = '0;
          if (ramping) begin
            ratio = ((64'(release_us) - 64'(elapsed_total)) << jgrr_pkg::FRAC_W)
                    / 64'(release_us);
          end
          for (int k = 0; k < n; k++) begin
            add_row(k, n, ramping, ramp_on ? hold_pos[k] : '0,
                    ramping ? scaled(kp_init[k], ratio) : '0,
                    ramping ? scaled(kd_init[k], ratio) : '0, !ramping);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_row(logic [jgrr_pkg::OUT_DATA_W-1:0] data, logic last);
      joint_row_t  got;
      row_expect_t want;
      string       tag;
      got = data;
      rows_seen++;
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected beat for joint %0d", got.joint));
        return;
      end
      want = rows_due.pop_front();
      tag = $sformatf("beat %0d joint %0d", rows_seen, want.row.joint);
      if (got.joint !== want.row.joint)
        report($sformatf("%s out_joint got %0d", tag, got.joint));
      if (got.drive_enable !== want.row.drive_enable)
        report($sformatf("%s drive_enable got %b", tag, got.drive_enable));
      if (got.target_position !== want.row.target_position)
        report($sformatf("%s target got %h want %h", tag, got.target_position,
                         want.row.target_position));
      if (got.kp_out !== want.row.kp_out)
        report($sformatf("%s kp got %h want %h", tag, got.kp_out, want.row.kp_out));
      if (got.kd_out !== want.row.kd_out)
        report($sformatf("%s kd got %h want %h", tag, got.kd_out, want.row.kd_out));
      if (got.finished !== want.row.finished)
        report($sformatf("%s finished got %b", tag, got.finished));
      if (last !== want.last)
        report($sformatf("%s tlast got %b", tag, last));
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [jgrr_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic [jgrr_pkg::KIND_W-1:0]       in_tuser = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [jgrr_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              out_tlast;
  logic                              cfg_we = 1'b0;
  logic [jgrr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [jgrr_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  release_scoreboard sb = new();

  int unsigned quiet_cycles = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_style = 0;
  int unsigned burst_left = 1;
  int unsigned kind_seen [4] = '{default: 0};
  int unsigned reg_writes = 0;

  joint_gain_release_ramp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check beats, drive the stall pattern and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_row(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    stall_tick++;
    if (stall_tick % 150 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((stall_tick % 7) < 3);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic drive_cmd_t rand_cmd();
    drive_cmd_t c;
    c.pad              = 1'b0;
    c.elapsed_us       = jgrr_pkg::ELAPSED_W'($urandom_range(0, ELAPSED_MAX_US));
    c.fault_limit_code = 1'($urandom_range(0, 1));
    c.fault_source     = 2'($urandom_range(0, 3));
    c.fault_active     = 1'($urandom_range(0, 1));
    c.drive_enabled    = 1'($urandom_range(0, 1));
    c.kd_gain          = $urandom;
    c.kp_gain          = $urandom;
    c.values_finite    = 1'($urandom_range(0, 1));
    c.joint_position   = $urandom;
    c.joint_index      = jgrr_pkg::JOINT_W'($urandom_range(0, 31));
    return c;
  endfunction

  function automatic logic [31:0] rand_gain(bit negative);
    logic [31:0] g;
    g = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32'h00FF_FFFF) : $urandom;
    g[31] = negative;
    return g;
  endfunction

  // Called just after a rising edge; returns after the beat is taken and any pause.
  task automatic send(input logic [jgrr_pkg::KIND_W-1:0] kind, input drive_cmd_t c);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, c);
    kind_seen[kind]++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  task automatic load(input int j, input logic [31:0] pos, input logic [31:0] kp,
                      input logic [31:0] kd, input bit finite);
    drive_cmd_t c;
    c = rand_cmd();
    c.joint_index    = j[jgrr_pkg::JOINT_W-1:0];
    c.joint_position = pos;
    c.kp_gain        = kp;
    c.kd_gain        = kd;
    c.values_finite  = finite;
    send(jgrr_pkg::KIND_LOAD, c);
  endtask

  task automatic load_random(input int j, input bit good);
    bit finite;
    bit neg_kp;
    bit neg_kd;
    finite = 1'b1;
    neg_kp = 1'b0;
    neg_kd = 1'b0;
    if (!good) begin
      case ($urandom_range(0, 2))
        0: finite = 1'b0;
        1: neg_kp = 1'b1;
        default: neg_kd = 1'b1;
      endcase
    end
    load(j, $urandom, rand_gain(neg_kp), rand_gain(neg_kd), finite);
  endtask

  task automatic enter(input bit drive, input bit active, input logic [1:0] src,
                       input bit limit);
    drive_cmd_t c;
    c = rand_cmd();
    c.drive_enabled    = drive;
    c.fault_active     = active;
    c.fault_source     = src;
    c.fault_limit_code = limit;
    send(jgrr_pkg::KIND_ENTER, c);
  endtask

  task automatic tick(input int unsigned us);
    drive_cmd_t c;
    c = rand_cmd();
    c.elapsed_us = jgrr_pkg::ELAPSED_W'(us);
    send(jgrr_pkg::KIND_TICK, c);
  endtask

  // Hold the sender off until every expected beat is out and the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.rows_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [jgrr_pkg::CFG_IDX_W-1:0] idx,
                         input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= jgrr_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, jgrr_pkg::CFG_DATA_W'(value));
    reg_writes++;
  endtask

  initial begin
    int unsigned random_goal;
    int unsigned n;
    int unsigned t_cfg;
    int unsigned span;
    int unsigned pick;
    bit          good;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing captured yet: a tick reports finished rows and an enter is refused.
    tick(0);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    send(KIND_UNUSED, rand_cmd());
    settle();
    set_reg(jgrr_pkg::CFG_JOINT_COUNT, 3);
    set_reg(jgrr_pkg::CFG_RELEASE_TIME, 1000);
    load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1);
    load(1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1);
    load(2, 32'hFFFF_FFFF, 32'h8000_0000, 32'd5, 1'b1);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    load(2, 32'd12345, 32'h0001_0000, 32'h0010_0000, 1'b0);
    load(2, 32'hDEAD_BEEF, 32'd7, 32'hFFFF_FFF0, 1'b1);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    load(2, $urandom, 32'h0003_0000, 32'd100, 1'b1);
    enter(1'b0, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    enter(1'b1, 1'b0, jgrr_pkg::SRC_POLICY, 1'b0);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_SAFETY, 1'b0);
    enter(1'b1, 1'b1, SRC_OTHER, 1'b1);
    enter(1'b1, 1'b1, SRC_UNUSED, 1'b1);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_SAFETY, 1'b1);
    tick(0);
    tick(250);
    // A load in the middle of the ramp replaces the gains for later rows.
    load(1, $urandom, 32'h0000_8000, 32'h7FFF_FFFF, 1'b1);
    tick(500);
    tick(ELAPSED_MAX_US);
    tick(0);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    tick(999);
    load(31, $urandom, $urandom, $urandom, 1'b1);

    // With no joints in use nothing comes out, but the timer still runs.
    settle();
    set_reg(jgrr_pkg::CFG_JOINT_COUNT, 0);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    tick(ELAPSED_MAX_US);
    send(KIND_UNUSED, rand_cmd());
    settle();
    // An oversized joint count saturates at the row limit; a zero release time
    // finishes at once, and a release time of one gives a full ratio at time zero.
    set_reg(jgrr_pkg::CFG_JOINT_COUNT, 63);
    set_reg(jgrr_pkg::CFG_RELEASE_TIME, 0);
    for (int j = 0; j < jgrr_pkg::ROW_LIMIT; j++) load_random(j, 1'b1);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_SAFETY, 1'b1);
    tick(0);
    settle();
    set_reg(jgrr_pkg::CFG_RELEASE_TIME, 1);
    tick(0);
    tick(1);

    random_goal = kind_seen[jgrr_pkg::KIND_LOAD] + kind_seen[jgrr_pkg::KIND_ENTER]
                  + kind_seen[jgrr_pkg::KIND_TICK] + RANDOM_ITEMS;
    while (kind_seen[jgrr_pkg::KIND_LOAD] + kind_seen[jgrr_pkg::KIND_ENTER]
           + kind_seen[jgrr_pkg::KIND_TICK] < random_goal) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick <= 5) n = $urandom_range(1, 4);
      else if (pick <= 7) n = $urandom_range(5, 12);
      else if (pick == 8) n = jgrr_pkg::ROW_LIMIT;
      else n = $urandom_range(1, jgrr_pkg::ROW_LIMIT);
      pick = $urandom_range(0, 9);
      if (pick == 0) t_cfg = 0;
      else if (pick == 1) t_cfg = 1;
      else if (pick == 2) t_cfg = 100000000;
      else if (pick <= 6) t_cfg = $urandom_range(50, 5000);
      else if (pick <= 8) t_cfg = $urandom_range(5000, 2000000);
      else t_cfg = $urandom_range(0, 100000000);
      set_reg(jgrr_pkg::CFG_JOINT_COUNT, n);
      set_reg(jgrr_pkg::CFG_RELEASE_TIME, t_cfg);
      // Every joint in use is captured first, so no row ever reads an empty entry.
      for (int s = 0; s < $urandom_range(1, 3); s++) begin
        for (int j = 0; j < n; j++) begin
          if (s == 0 || $urandom_range(0, 2) == 0) load_random(j, $urandom_range(0, 32) != 0);
        end
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 1) send(KIND_UNUSED, rand_cmd());
          else load_random($urandom_range(0, 31), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 4) != 0) begin
          good = 1'($urandom_range(0, 1));
          enter(1'b1, 1'b1, good ? jgrr_pkg::SRC_POLICY : jgrr_pkg::SRC_SAFETY,
                good ? 1'($urandom_range(0, 1)) : 1'b1);
        end else begin
          send(jgrr_pkg::KIND_ENTER, rand_cmd());
        end
        for (int k = 0; k < $urandom_range(1, 8); k++) begin
          span = ELAPSED_MAX_US;
          if (t_cfg > 0 && $urandom_range(0, 4) != 0 && t_cfg / 4 + 1 < span)
            span = t_cfg / 4 + 1;
          tick($urandom_range(0, span));
          if ($urandom_range(0, 9) == 0) load_random($urandom_range(0, n - 1), 1'b1);
        end
        if ($urandom_range(0, 4) == 0) settle();
      end
    end

    // Long run at the largest release time: the ramp runs down and then finishes.
    settle();
    set_reg(jgrr_pkg::CFG_JOINT_COUNT, 1);
    set_reg(jgrr_pkg::CFG_RELEASE_TIME, 100000000);
    load_random(0, 1'b1);
    enter(1'b1, 1'b1, jgrr_pkg::SRC_POLICY, 1'b0);
    repeat (SOAK_TICKS) tick(ELAPSED_MAX_US);
    tick(0);

    settle();
    if (sb.rows_due.size() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.rows_due.size()));
    $display("Sent %0d loads, %0d enters, %0d ticks and %0d unused-kind beats;",
             kind_seen[jgrr_pkg::KIND_LOAD], kind_seen[jgrr_pkg::KIND_ENTER],
             kind_seen[jgrr_pkg::KIND_TICK], kind_seen[KIND_UNUSED]);
    $display("checked %0d result beats across %0d register writes, %0d errors.",
             sb.rows_seen, reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/jgrr_pkg.sv
hdl/jgrr_ram.sv
hdl/jgrr_front.sv
hdl/jgrr_queue.sv
hdl/jgrr_back.sv
hdl/joint_gain_release_ramp.sv
tb/tb_joint_gain_release_ramp.sv
